/* hdl/rwv_pkg.sv */
// Package for the running weighted variance block: payload types, status codes,
// sequencer states and width constants. No dependencies.
`timescale 1ns / 1ps
package rwv_pkg;

  localparam int DataWidth  = 32;
  localparam int FracBits   = 16;
  localparam int WtBits     = DataWidth + FracBits;  // weight total, unsigned integer (Q48.0)
  localparam int VarBits    = DataWidth + FracBits;  // variance, Q32.16
  localparam int AccBits    = 64;                    // S and Q accumulators
  localparam int MulABits   = 64;                    // multiplicand of serial multiplier
  localparam int MulBBits   = 50;                    // multiplier, one bit per cycle
  localparam int MulPBits   = MulABits + MulBBits;
  localparam int DivBits    = 96;                    // divisor / remainder width
  localparam int FeedBits   = 48;                    // numerator bits fed per variance division
  localparam int DeltaSteps = 33;                    // quotient bits of the mean step
  localparam int CntBits    = 7;

  typedef struct packed {
    logic                        start_sequence;
    logic signed [DataWidth-1:0] sample;
    logic        [DataWidth-1:0] weight;
  } in_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] running_mean;
    logic        [VarBits-1:0]   running_variance;
    logic        [1:0]           status;
  } out_req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_WT   = 2'd1,
    STAT_CORR_UNDEF = 2'd2,
    STAT_SAT       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_DW,
    ST_DIV_DELTA,
    ST_MUL_T1,
    ST_MUL_T2,
    ST_MUL_SQ,
    ST_MUL_W2,
    ST_MUL_NUM,
    ST_VCHK,
    ST_DIV_VAR,
    ST_RES
  } state_t;

endpackage

/* hdl/running_weighted_variance_top.sv */
// Running weighted variance (West's incremental update), bit-serial datapath.
// Depends on rwv_pkg for payload structs, status codes and sequencer states.
//
//  channel | ports                        | payload
//  --------+------------------------------+------------------------------
//  input   | in_valid  in_ready  in_data  | start flag, sample, weight
//  result  | out_valid out_ready out_data | mean, variance, status
//  config  | cfg_valid cfg_ready cfg_data | unbiased correction enable
//
// One item at a time. A shared shift-add multiplier (one multiplier bit per
// cycle) and a restoring divider (one quotient bit per cycle) set the rate:
// an item takes longer with correction on, less when the variance saturates
// early or the correction is undefined, and least when its weight sum is zero.
// Reset clears the accumulators, the correction bit and the output valid flag.
// A result held by out_ready low stalls the block only when the next one is done.
`timescale 1ns / 1ps
module running_weighted_variance_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rwv_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rwv_pkg::out_req_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  rwv_pkg::state_t state_r, state_nxt;

  // architectural state
  logic        [rwv_pkg::WtBits-1:0]    w_total_r;
  logic signed [rwv_pkg::DataWidth-1:0] mean_r;
  logic        [rwv_pkg::AccBits-1:0]   dev_sum_r;
  logic        [rwv_pkg::AccBits-1:0]   wsq_total_r;
  logic                                 corr_r;

  // per-item registers
  rwv_pkg::in_req_t                     item_r;
  logic        [rwv_pkg::WtBits-1:0]    wnew_r;
  logic        [32:0]                   dmag_r;
  logic                                 neg_r;
  logic                                 sat_r;
  logic        [rwv_pkg::VarBits-1:0]   var_r;
  rwv_pkg::status_t                     stat_r;
  logic        [rwv_pkg::CntBits-1:0]   cnt_r;

  // serial multiplier
  logic [rwv_pkg::MulABits-1:0] mul_a_r;
  logic [rwv_pkg::MulBBits-1:0] mul_b_r;
  logic [rwv_pkg::MulPBits-1:0] mul_p_r;
  logic [rwv_pkg::MulABits:0]   mul_sum;

  // serial divider
  logic [rwv_pkg::DivBits-1:0]  rem_r;
  logic [rwv_pkg::DivBits-1:0]  den_r;
  logic [rwv_pkg::FeedBits-1:0] feed_r;
  logic [rwv_pkg::FeedBits-1:0] quo_r;
  logic [rwv_pkg::DivBits:0]    div_t;
  logic [rwv_pkg::DivBits:0]    div_diff;
  logic                         div_ge;

  // output register
  rwv_pkg::out_req_t out_data_r;
  logic              out_valid_r;

  // combinational helpers
  logic [rwv_pkg::WtBits:0]  wsum;
  logic [32:0]               diff;
  logic                      unit_busy;
  logic                      wnew_zero;
  logic                      w2_le_q;
  logic                      rem_ovf;
  logic [33:0]               mean_upd;
  logic [rwv_pkg::AccBits:0] s_sum;
  logic [rwv_pkg::AccBits:0] q_sum;
  logic [rwv_pkg::AccBits-1:0] t2;

  assign unit_busy = (cnt_r != '0);
  assign wsum      = {1'b0, w_total_r} + {{(rwv_pkg::WtBits-rwv_pkg::DataWidth+1){1'b0}},
                                          item_r.weight};
  assign wnew_zero = (wsum == '0);
  assign diff      = {item_r.sample[31], item_r.sample} - {mean_r[31], mean_r};
  assign w2_le_q   = (mul_p_r[95:0] <= {32'b0, wsq_total_r});
  assign rem_ovf   = (rem_r >= den_r);

  // multiplier step: add multiplicand on low multiplier bit, shift right
  assign mul_sum = {1'b0, mul_p_r[rwv_pkg::MulPBits-1:rwv_pkg::MulBBits]}
                 + ({(rwv_pkg::MulABits+1){mul_b_r[0]}} & {1'b0, mul_a_r});

  // divider step: shift in next numerator bit, trial subtract
  assign div_t    = {rem_r, feed_r[rwv_pkg::FeedBits-1]};
  assign div_ge   = (div_t >= {1'b0, den_r});
  assign div_diff = div_t - {1'b0, den_r};

  // datapath adders used at the end of the mean division and the multiply steps
  assign mean_upd = neg_r ? ({{2{mean_r[31]}}, mean_r} - {1'b0, quo_r[32:0]})
                          : ({{2{mean_r[31]}}, mean_r} + {1'b0, quo_r[32:0]});
  assign t2       = (mul_p_r[113:80] != '0) ? '1 : mul_p_r[79:16];
  assign s_sum    = {1'b0, dev_sum_r} + {1'b0, t2};
  assign q_sum    = {1'b0, wsq_total_r} + {1'b0, mul_p_r[63:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rwv_pkg::ST_IDLE:      if (in_valid) state_nxt = rwv_pkg::ST_PREP;
      rwv_pkg::ST_PREP:      state_nxt = wnew_zero ? rwv_pkg::ST_RES : rwv_pkg::ST_MUL_DW;
      rwv_pkg::ST_MUL_DW:    if (!unit_busy) state_nxt = rwv_pkg::ST_DIV_DELTA;
      rwv_pkg::ST_DIV_DELTA: if (!unit_busy) state_nxt = rwv_pkg::ST_MUL_T1;
      rwv_pkg::ST_MUL_T1:    if (!unit_busy) state_nxt = rwv_pkg::ST_MUL_T2;
      rwv_pkg::ST_MUL_T2:    if (!unit_busy) state_nxt = rwv_pkg::ST_MUL_SQ;
      rwv_pkg::ST_MUL_SQ:    if (!unit_busy) state_nxt = corr_r ? rwv_pkg::ST_MUL_W2
                                                                : rwv_pkg::ST_VCHK;
      rwv_pkg::ST_MUL_W2:    if (!unit_busy) state_nxt = w2_le_q ? rwv_pkg::ST_RES
                                                                 : rwv_pkg::ST_MUL_NUM;
      rwv_pkg::ST_MUL_NUM:   if (!unit_busy) state_nxt = rwv_pkg::ST_VCHK;
      rwv_pkg::ST_VCHK:      state_nxt = rem_ovf ? rwv_pkg::ST_RES : rwv_pkg::ST_DIV_VAR;
      rwv_pkg::ST_DIV_VAR:   if (!unit_busy) state_nxt = rwv_pkg::ST_RES;
      rwv_pkg::ST_RES:       if (!out_valid_r || out_ready) state_nxt = rwv_pkg::ST_IDLE;
      default:               state_nxt = rwv_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == rwv_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      corr_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) corr_r <= cfg_data;
      if (state_r == rwv_pkg::ST_RES && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // accumulators and sequenced datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_total_r   <= '0;
      mean_r      <= '0;
      dev_sum_r   <= '0;
      wsq_total_r <= '0;
      cnt_r       <= '0;
    end else begin
      // units step while the counter runs
      if (unit_busy) begin
        cnt_r   <= cnt_r - 1'b1;
        mul_p_r <= {mul_sum, mul_p_r[rwv_pkg::MulBBits-1:1]};
        mul_b_r <= mul_b_r >> 1;
        rem_r   <= div_ge ? div_diff[rwv_pkg::DivBits-1:0] : div_t[rwv_pkg::DivBits-1:0];
        quo_r   <= {quo_r[rwv_pkg::FeedBits-2:0], div_ge};
        feed_r  <= feed_r << 1;
      end
      case (state_r)
        rwv_pkg::ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            sat_r  <= 1'b0;
            if (in_data.start_sequence) begin
              w_total_r   <= '0;
              mean_r      <= '0;
              dev_sum_r   <= '0;
              wsq_total_r <= '0;
            end
          end
        end
        rwv_pkg::ST_PREP: begin
          wnew_r <= wsum[rwv_pkg::WtBits] ? '1 : wsum[rwv_pkg::WtBits-1:0];
          if (wsum[rwv_pkg::WtBits]) sat_r <= 1'b1;
          neg_r  <= diff[32];
          dmag_r <= diff[32] ? (33'd0 - diff) : diff;
          if (wnew_zero) begin
            w_total_r <= '0;
            var_r     <= '0;
            stat_r    <= rwv_pkg::STAT_ZERO_WT;
          end else begin
            mul_a_r <= {31'b0, (diff[32] ? (33'd0 - diff) : diff)};
            mul_b_r <= {18'b0, item_r.weight};
            mul_p_r <= '0;
            cnt_r   <= 7'(rwv_pkg::MulBBits);
          end
        end
        rwv_pkg::ST_MUL_DW: begin
          if (!unit_busy) begin
            // quotient never exceeds dmag, so 33 steps suffice
            den_r  <= {48'b0, wnew_r};
            rem_r  <= {63'b0, mul_p_r[65:33]};
            feed_r <= {mul_p_r[32:0], 15'b0};
            quo_r  <= '0;
            cnt_r  <= 7'(rwv_pkg::DeltaSteps);
          end
        end
        rwv_pkg::ST_DIV_DELTA: begin
          if (!unit_busy) begin
            mean_r  <= mean_upd[31:0];
            mul_a_r <= {31'b0, dmag_r};
            mul_b_r <= {17'b0, quo_r[32:0]};
            mul_p_r <= '0;
            cnt_r   <= 7'(rwv_pkg::MulBBits);
          end
        end
        rwv_pkg::ST_MUL_T1: begin
          if (!unit_busy) begin
            mul_a_r <= {14'b0, mul_p_r[65:16]};
            mul_b_r <= {2'b0, w_total_r};
            mul_p_r <= '0;
            cnt_r   <= 7'(rwv_pkg::MulBBits);
          end
        end
        rwv_pkg::ST_MUL_T2: begin
          if (!unit_busy) begin
            if (mul_p_r[113:80] != '0 || s_sum[rwv_pkg::AccBits]) sat_r <= 1'b1;
            dev_sum_r <= s_sum[rwv_pkg::AccBits] ? '1 : s_sum[rwv_pkg::AccBits-1:0];
            mul_a_r   <= {32'b0, item_r.weight};
            mul_b_r   <= {18'b0, item_r.weight};
            mul_p_r   <= '0;
            cnt_r     <= 7'(rwv_pkg::MulBBits);
          end
        end
        rwv_pkg::ST_MUL_SQ: begin
          if (!unit_busy) begin
            if (q_sum[rwv_pkg::AccBits]) sat_r <= 1'b1;
            wsq_total_r <= q_sum[rwv_pkg::AccBits] ? '1 : q_sum[rwv_pkg::AccBits-1:0];
            w_total_r   <= wnew_r;
            if (corr_r) begin
              mul_a_r <= {16'b0, wnew_r};
              mul_b_r <= {2'b0, wnew_r};
              mul_p_r <= '0;
              cnt_r   <= 7'(rwv_pkg::MulBBits);
            end else begin
              // (S << 16) / W: top part preloaded, low 48 bits fed serially
              den_r  <= {48'b0, wnew_r};
              rem_r  <= {64'b0, dev_sum_r[63:32]};
              feed_r <= {dev_sum_r[31:0], 16'b0};
              quo_r  <= '0;
            end
          end
        end
        rwv_pkg::ST_MUL_W2: begin
          if (!unit_busy) begin
            if (w2_le_q) begin
              var_r  <= '0;
              stat_r <= rwv_pkg::STAT_CORR_UNDEF;
            end else begin
              den_r   <= mul_p_r[95:0] - {32'b0, wsq_total_r};
              mul_a_r <= dev_sum_r;
              mul_b_r <= {2'b0, wnew_r};
              mul_p_r <= '0;
              cnt_r   <= 7'(rwv_pkg::MulBBits);
            end
          end
        end
        rwv_pkg::ST_MUL_NUM: begin
          if (!unit_busy) begin
            rem_r  <= {16'b0, mul_p_r[111:32]};
            feed_r <= {mul_p_r[31:0], 16'b0};
            quo_r  <= '0;
          end
        end
        rwv_pkg::ST_VCHK: begin
          // a preloaded remainder at or above the divisor means quotient >= 2^48
          if (rem_ovf) begin
            var_r  <= '1;
            stat_r <= rwv_pkg::STAT_SAT;
          end else begin
            cnt_r <= 7'(rwv_pkg::FeedBits);
          end
        end
        rwv_pkg::ST_DIV_VAR: begin
          if (!unit_busy) begin
            var_r  <= quo_r;
            stat_r <= sat_r ? rwv_pkg::STAT_SAT : rwv_pkg::STAT_OK;
          end
        end
        rwv_pkg::ST_RES: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.running_mean     <= mean_r;
            out_data_r.running_variance <= var_r;
            out_data_r.status           <= stat_r;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == rwv_pkg::ST_PREP))
    else $error("accepted request did not enter preparation");

  a_zero_wt_var: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == rwv_pkg::STAT_ZERO_WT)
      |-> (out_data_r.running_variance == '0))
    else $error("zero weight result with nonzero variance");

  a_undef_var: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == rwv_pkg::STAT_CORR_UNDEF)
      |-> (out_data_r.running_variance == '0))
    else $error("undefined correction with nonzero variance");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 7'(rwv_pkg::MulBBits))
    else $error("step counter out of range");

endmodule
